// ===== hw/rtl/register_reply_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// register_reply_deframer_defines.svh
// Assertion macros for the register reply deframer.
// ----------------------------------------------------------------------------
`ifndef REGISTER_REPLY_DEFRAMER_DEFINES_SVH
`define REGISTER_REPLY_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

`define RRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define RRD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define RRD_ASSERT(label, prop, msg)

`define RRD_ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ===== hw/rtl/rrd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrd_pkg
// Types, constants and the CRC-8 step shared by the register reply deframer.
// ----------------------------------------------------------------------------
package rrd_pkg;

  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] SYNC_BYTE   = 8'h05;
  localparam logic [7:0] MASTER_BYTE = 8'hFF;
  localparam logic [2:0] DATA_BYTES  = 3'd4;

  localparam int unsigned REG_W  = 7;
  localparam int unsigned ADDR_W = 3;

  typedef enum logic {
    FUNC_BYTE    = 1'b0,
    FUNC_RESTART = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_CRC_ZERO = 2'd2
  } status_e;

  typedef enum logic {
    PH_HUNT    = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] rx_byte;
  } rrd_item_t;

  typedef struct packed {
    logic [31:0] data_word;
    status_e     status;
  } rrd_result_t;

  // CRC-8, data taken LSB first
  function automatic logic [7:0] crc_feed(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[7] ^ data[i]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC over the two fixed sync bytes
  localparam logic [7:0] SYNC_CRC = crc_feed(crc_feed(8'h00, SYNC_BYTE), MASTER_BYTE);

endpackage

// ===== hw/rtl/rrd_core.sv =====
// ----------------------------------------------------------------------------
// rrd_core
// Frame tracker: sync hunt, payload collection, CRC check, one byte a step.
// ----------------------------------------------------------------------------
`include "register_reply_deframer_defines.svh"

module rrd_core import rrd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  rrd_item_t          item_i,
  input  logic [REG_W-1:0]   expected_reg_i,
  output logic               res_hit_o,
  output rrd_result_t        result_o
);

  phase_e      phase_q, phase_d;
  logic [23:0] window_q, window_d;
  logic [2:0]  count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic [31:0] accum_q, accum_d;

  logic [23:0] window_shift;
  logic        match;
  logic        restart;
  logic        last_byte;

  assign restart      = (item_i.func == FUNC_RESTART);
  assign window_shift = {window_q[15:0], item_i.rx_byte};
  assign match        = (window_shift == {SYNC_BYTE, MASTER_BYTE, 1'b0, expected_reg_i});
  assign last_byte    = (count_q == DATA_BYTES);

  // next state
  always_comb begin
    phase_d = phase_q;
    if (step_en_i) begin
      if (restart) begin
        phase_d = PH_HUNT;
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            if (match) phase_d = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (last_byte) phase_d = PH_HUNT;
          end
          default: phase_d = PH_HUNT;
        endcase
      end
    end
  end

  // datapath and outputs
  always_comb begin
    window_d  = window_q;
    count_d   = count_q;
    crc_d     = crc_q;
    accum_d   = accum_q;
    res_hit_o = (phase_q == PH_PAYLOAD) && last_byte && !restart;

    result_o.data_word = accum_q;
    if (item_i.rx_byte != crc_q) begin
      result_o.status = ST_CRC_BAD;
    end else if (item_i.rx_byte == 8'h00) begin
      result_o.status = ST_CRC_ZERO;
    end else begin
      result_o.status = ST_GOOD;
    end

    if (step_en_i) begin
      if (restart) begin
        window_d = '0;
        count_d  = '0;
        crc_d    = '0;
        accum_d  = '0;
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            window_d = window_shift;
            if (match) begin
              count_d = '0;
              accum_d = '0;
              crc_d   = crc_feed(SYNC_CRC, item_i.rx_byte);
            end
          end
          PH_PAYLOAD: begin
            if (last_byte) begin
              window_d = '0;
              count_d  = '0;
              crc_d    = '0;
              accum_d  = '0;
            end else begin
              accum_d = {accum_q[23:0], item_i.rx_byte};
              crc_d   = crc_feed(crc_q, item_i.rx_byte);
              count_d = count_q + 3'd1;
            end
          end
          default: begin
            window_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      window_q <= '0;
      count_q  <= '0;
      crc_q    <= '0;
      accum_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      window_q <= window_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      accum_q  <= accum_d;
    end
  end

  `RRD_ASSERT_NEVER(a_count_range, count_q > DATA_BYTES, "payload count out of range")
  `RRD_ASSERT(a_hunt_clean, phase_q == PH_HUNT |-> count_q == '0 && crc_q == '0,
              "stale frame progress while hunting")
  `RRD_ASSERT(a_frame_end, step_en_i && res_hit_o |=> phase_q == PH_HUNT && window_q == '0,
              "window not cleared after frame")
  `RRD_ASSERT(a_restart, step_en_i && restart |=> phase_q == PH_HUNT && accum_q == '0,
              "restart did not clear frame")

endmodule

// ===== hw/rtl/register_reply_deframer.sv =====
// ----------------------------------------------------------------------------
// register_reply_deframer
// Register reply deframer with APB configuration and valid/stall channels.
// ----------------------------------------------------------------------------
// Accepts one received byte (or a restart request) per clock cycle while not
// stalled. Each request is captured in an input register, goes through one
// CRC-8 byte step and the sync match, and a frame result is written into the
// output register when the CRC byte leaves the input register. Throughput is
// one request a cycle, set by the single byte-wide CRC step between the two
// registers; input stalls only when a frame's CRC byte meets an earlier result
// still waiting downstream. The awaited register number sits at APB address 0.
// ----------------------------------------------------------------------------
module register_reply_deframer import rrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       data_word_o,
  output logic [1:0]        status_o
);

  logic [REG_W-1:0] expected_reg_q;
  logic             reg_sel;

  logic        in_valid_q, in_valid_d;
  rrd_item_t   item_q;
  logic        out_valid_q, out_valid_d;
  rrd_result_t result_q;

  logic        res_hit;
  rrd_result_t result;
  logic        out_free;
  logic        advance;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == 1'b0);
  assign prdata  = reg_sel ? {{(32-REG_W){1'b0}}, expected_reg_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_reg_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      expected_reg_q <= pwdata[REG_W-1:0];
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!res_hit || out_free);
  assign in_stall_o = in_valid_q && !advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (!in_stall_o) in_valid_d = in_valid_i;
    out_valid_d = out_valid_q && out_stall_i;
    if (advance && res_hit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.func    <= func_e'(func_i);
      item_q.rx_byte <= rx_byte_i;
    end
    if (advance && res_hit) begin
      result_q <= result;
    end
  end

  rrd_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_en_i      (advance),
    .item_i         (item_q),
    .expected_reg_i (expected_reg_q),
    .res_hit_o      (res_hit),
    .result_o       (result)
  );

  assign out_valid_o = out_valid_q;
  assign data_word_o = result_q.data_word;
  assign status_o    = result_q.status;

endmodule
